FILE: rtl/stdf_pkg.sv
// Package for the SeaTalk datagram deframer: widths, byte codes, state types
// and the control struct passed from the deframer core to the frame store.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stdf_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned LEN_W         = 5;
  localparam int unsigned MAX_FRAME_DEF = 18;

  localparam logic [BYTE_W-1:0] BYTE_MARK = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_NULL = 8'h00;

  localparam logic [LEN_W-1:0] ATTR_BIAS = 5'd3;
  localparam logic [LEN_W-1:0] HDR_LEN   = 5'd2;
  localparam logic [LEN_W-1:0] POS_CMD   = 5'd0;
  localparam logic [LEN_W-1:0] POS_ATTR  = 5'd1;

  typedef enum logic [1:0] {
    MARK_NONE = 2'd0,
    MARK_FF   = 2'd1,
    MARK_FF00 = 2'd2
  } mark_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAKE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              wr_en;
    logic [LEN_W-1:0]  wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              emit_start;
    logic [LEN_W-1:0]  emit_len;
  } store_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/stdf_if.sv
// Request channel interfaces of the SeaTalk datagram deframer.
// Depends on stdf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface stdf_rx_if;
  logic                      valid;
  logic                      ready;
  logic [stdf_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface stdf_frame_if;
  logic                       valid;
  logic                       ready;
  logic [stdf_pkg::BYTE_W-1:0] frame_byte;
  logic [stdf_pkg::LEN_W-1:0]  byte_position;
  logic                       frame_last;

  modport source (output valid, output frame_byte, output byte_position,
                  output frame_last, input ready);
  modport sink (input valid, input frame_byte, input byte_position,
                input frame_last, output ready);
endinterface

`default_nettype wire

FILE: rtl/stdf_store.sv
// Datagram byte memory with a streaming readout into the output register.
// Depends on stdf_pkg and stdf_if.
`timescale 1ns / 1ps
`default_nettype none

module stdf_store #(
  parameter int unsigned MAX_FRAME = stdf_pkg::MAX_FRAME_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  stdf_pkg::store_ctl_t ctl_i,
  output logic                 busy_o,
  stdf_frame_if.source         frame_o
);

  localparam int unsigned AW = $clog2(MAX_FRAME);

  logic [stdf_pkg::BYTE_W-1:0] mem [MAX_FRAME];

  logic                         issuing_q, issuing_d;
  logic [stdf_pkg::LEN_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [stdf_pkg::LEN_W-1:0]   len_q, len_d;
  logic                         rv_q, rv_d;
  logic                         out_valid_q, out_valid_d;
  logic [stdf_pkg::BYTE_W-1:0]  rdata_q;
  logic [stdf_pkg::LEN_W-1:0]   rpos_q;
  logic                         rlast_q;
  logic [stdf_pkg::BYTE_W-1:0]  out_byte_q;
  logic [stdf_pkg::LEN_W-1:0]   out_pos_q;
  logic                         out_last_q;
  logic                         load_out;
  logic                         rd_en;
  logic                         rd_is_last;

  assign load_out   = rv_q && (!out_valid_q || frame_o.ready);
  assign rd_en      = issuing_q && (!rv_q || load_out);
  assign rd_is_last = (rd_ptr_q == len_q - stdf_pkg::LEN_W'(1));

  always_comb begin
    issuing_d   = issuing_q;
    rd_ptr_d    = rd_ptr_q;
    len_d       = len_q;
    rv_d        = rv_q;
    out_valid_d = out_valid_q;
    if (ctl_i.emit_start) begin
      issuing_d = 1'b1;
      rd_ptr_d  = '0;
      len_d     = ctl_i.emit_len;
    end else if (rd_en) begin
      rd_ptr_d = rd_ptr_q + stdf_pkg::LEN_W'(1);
      if (rd_is_last) begin
        issuing_d = 1'b0;
      end
    end
    if (rd_en) begin
      rv_d = 1'b1;
    end else if (load_out) begin
      rv_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (frame_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issuing_q   <= 1'b0;
      rd_ptr_q    <= '0;
      len_q       <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      issuing_q   <= issuing_d;
      rd_ptr_q    <= rd_ptr_d;
      len_q       <= len_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[ctl_i.wr_addr[AW-1:0]] <= ctl_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_ptr_q[AW-1:0]];
      rpos_q  <= rd_ptr_q;
      rlast_q <= rd_is_last;
    end
    if (load_out) begin
      out_byte_q <= rdata_q;
      out_pos_q  <= rpos_q;
      out_last_q <= rlast_q;
    end
  end

  assign busy_o                = issuing_q;
  assign frame_o.valid         = out_valid_q;
  assign frame_o.frame_byte    = out_byte_q;
  assign frame_o.byte_position = out_pos_q;
  assign frame_o.frame_last    = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/seatalk_datagram_deframer.sv
// SeaTalk datagram deframer: takes one received byte per request and accepts
// none while one is taken (a held 0xFF released with the next byte is taken
// first, then that byte). The byte that completes a datagram stalls input
// until the store has issued the readout; the bytes pass a read register and
// the output register and leave one per cycle while the output is ready.
// Reset clears the mark phase and framing state; the byte memory is not reset.
`timescale 1ns / 1ps
`default_nettype none

module seatalk_datagram_deframer #(
  parameter int unsigned MAX_FRAME = stdf_pkg::MAX_FRAME_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  stdf_rx_if.sink      rx_i,
  stdf_frame_if.source frame_o
);

  stdf_pkg::state_e             state_q, state_d;
  stdf_pkg::mark_e              mark_q, mark_d;
  logic [stdf_pkg::BYTE_W-1:0]  a_byte_q, a_byte_d;
  logic                         a_cmd_q, a_cmd_d;
  logic [stdf_pkg::BYTE_W-1:0]  b_byte_q, b_byte_d;
  logic                         b_cmd_q, b_cmd_d;
  logic                         b_vld_q, b_vld_d;
  logic                         in_frame_q, in_frame_d;
  logic                         await_q, await_d;
  logic [stdf_pkg::LEN_W-1:0]   len_q, len_d;
  logic [stdf_pkg::LEN_W-1:0]   left_q, left_d;

  stdf_pkg::store_ctl_t         ctl;
  logic                         store_busy;
  logic                         accept;
  logic                         in_parity;
  logic                         in_take;
  logic                         take_emit;
  logic [stdf_pkg::LEN_W-1:0]   attr_len;

  assign rx_i.ready = (state_q == stdf_pkg::ST_IDLE);
  assign accept     = rx_i.valid && rx_i.ready;
  assign in_parity  = ^rx_i.rx_byte;
  assign attr_len   = {1'b0, a_byte_q[3:0]} + stdf_pkg::ATTR_BIAS;

  always_comb begin
    in_take = 1'b0;
    if (accept) begin
      unique case (mark_q)
        stdf_pkg::MARK_FF:   in_take = (rx_i.rx_byte != stdf_pkg::BYTE_NULL);
        stdf_pkg::MARK_FF00: in_take = 1'b1;
        default:             in_take = (rx_i.rx_byte != stdf_pkg::BYTE_MARK);
      endcase
    end
  end

  assign take_emit = !a_cmd_q && in_frame_q && !await_q &&
                     (left_q == stdf_pkg::LEN_W'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stdf_pkg::ST_IDLE: begin
        if (in_take) begin
          state_d = stdf_pkg::ST_TAKE;
        end
      end
      stdf_pkg::ST_TAKE: begin
        if (take_emit) begin
          state_d = stdf_pkg::ST_EMIT;
        end else if (!b_vld_q) begin
          state_d = stdf_pkg::ST_IDLE;
        end
      end
      stdf_pkg::ST_EMIT: begin
        if (!store_busy) begin
          state_d = b_vld_q ? stdf_pkg::ST_TAKE : stdf_pkg::ST_IDLE;
        end
      end
      default: state_d = stdf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mark_d     = mark_q;
    a_byte_d   = a_byte_q;
    a_cmd_d    = a_cmd_q;
    b_byte_d   = b_byte_q;
    b_cmd_d    = b_cmd_q;
    b_vld_d    = b_vld_q;
    in_frame_d = in_frame_q;
    await_d    = await_q;
    len_d      = len_q;
    left_d     = left_q;
    ctl        = '0;
    unique case (state_q)
      stdf_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (mark_q)
            stdf_pkg::MARK_FF: begin
              if (rx_i.rx_byte == stdf_pkg::BYTE_NULL) begin
                mark_d = stdf_pkg::MARK_FF00;
              end else begin
                a_byte_d = stdf_pkg::BYTE_MARK;
                a_cmd_d  = 1'b0;
                if (rx_i.rx_byte != stdf_pkg::BYTE_MARK) begin
                  mark_d   = stdf_pkg::MARK_NONE;
                  b_byte_d = rx_i.rx_byte;
                  b_cmd_d  = in_parity;
                  b_vld_d  = 1'b1;
                end
              end
            end
            stdf_pkg::MARK_FF00: begin
              mark_d   = stdf_pkg::MARK_NONE;
              a_byte_d = rx_i.rx_byte;
              a_cmd_d  = !in_parity;
            end
            default: begin
              mark_d   = (rx_i.rx_byte == stdf_pkg::BYTE_MARK) ? stdf_pkg::MARK_FF
                                                               : stdf_pkg::MARK_NONE;
              a_byte_d = rx_i.rx_byte;
              a_cmd_d  = in_parity;
            end
          endcase
        end
      end
      stdf_pkg::ST_TAKE: begin
        if (a_cmd_q) begin
          ctl.wr_en   = 1'b1;
          ctl.wr_addr = stdf_pkg::POS_CMD;
          ctl.wr_data = a_byte_q;
          in_frame_d  = 1'b1;
          await_d     = 1'b1;
          left_d      = '0;
          len_d       = '0;
        end else if (in_frame_q) begin
          if (await_q) begin
            await_d = 1'b0;
            if (attr_len > stdf_pkg::LEN_W'(MAX_FRAME)) begin
              in_frame_d = 1'b0;
            end else begin
              len_d       = attr_len;
              left_d      = attr_len - stdf_pkg::HDR_LEN;
              ctl.wr_en   = 1'b1;
              ctl.wr_addr = stdf_pkg::POS_ATTR;
              ctl.wr_data = a_byte_q;
            end
          end else if (left_q == '0) begin
            in_frame_d = 1'b0;
          end else begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = len_q - left_q;
            ctl.wr_data = a_byte_q;
            left_d      = left_q - stdf_pkg::LEN_W'(1);
            if (take_emit) begin
              ctl.emit_start = 1'b1;
              ctl.emit_len   = len_q;
              in_frame_d     = 1'b0;
            end
          end
        end
        if (!take_emit && b_vld_q) begin
          a_byte_d = b_byte_q;
          a_cmd_d  = b_cmd_q;
          b_vld_d  = 1'b0;
        end
      end
      stdf_pkg::ST_EMIT: begin
        if (!store_busy && b_vld_q) begin
          a_byte_d = b_byte_q;
          a_cmd_d  = b_cmd_q;
          b_vld_d  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= stdf_pkg::ST_IDLE;
      mark_q     <= stdf_pkg::MARK_NONE;
      b_vld_q    <= 1'b0;
      in_frame_q <= 1'b0;
      await_q    <= 1'b0;
      len_q      <= '0;
      left_q     <= '0;
    end else begin
      state_q    <= state_d;
      mark_q     <= mark_d;
      b_vld_q    <= b_vld_d;
      in_frame_q <= in_frame_d;
      await_q    <= await_d;
      len_q      <= len_d;
      left_q     <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_byte_q <= a_byte_d;
    a_cmd_q  <= a_cmd_d;
    b_byte_q <= b_byte_d;
    b_cmd_q  <= b_cmd_d;
  end

  stdf_store #(
    .MAX_FRAME(MAX_FRAME)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .busy_o (store_busy),
    .frame_o(frame_o)
  );

endmodule

`default_nettype wire
